FILE: sv/bcst_pkg.sv
// bcst_pkg: shared types and constants of the battery cell and solar state tracker
// used by bcst_cnt_ram, the top level and the testbench; no dependencies
`default_nettype none

package bcst_pkg;

  localparam int unsigned MaxCellsDefault = 16;

  localparam int unsigned CntW    = 4;
  localparam logic [CntW-1:0] CntSat = 4'hF;

  localparam int unsigned PaddrW  = 5;
  localparam int unsigned PdataW  = 32;

  localparam int unsigned MaPerA  = 1000;
  localparam int unsigned ChgMaW  = 26;

  localparam logic [3:0]  CountThrRst  = 4'd3;
  localparam logic [6:0]  SocThrRst    = 7'd90;
  localparam logic [31:0] RetryDelayRst = 32'd120000;

  typedef enum logic [2:0] {
    REG_CELL_LOW   = 3'd0,
    REG_CELL_HIGH  = 3'd1,
    REG_TRACK_EN   = 3'd2,
    REG_COUNT_THR  = 3'd3,
    REG_CHARGE_THR = 3'd4,
    REG_SOC_THR    = 3'd5,
    REG_RETRY      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [CntW-1:0] high_cnt;
    logic [CntW-1:0] low_cnt;
  } cnt_pair_t;

endpackage

`default_nettype wire

FILE: sv/bcst_if.sv
// bcst_in_if and bcst_out_if: valid/ready request channels of the tracker
// depends on nothing; field widths follow the report and result items
`default_nettype none

interface bcst_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic               report_valid;
  logic [15:0]        cell_mv;
  logic               last_cell;
  logic signed [31:0] charge_ma;
  logic [6:0]         soc_percent;
  logic [31:0]        now_ms;

  modport source (
    output valid, mode, report_valid, cell_mv, last_cell, charge_ma, soc_percent, now_ms,
    input  ready
  );
  modport sink (
    input  valid, mode, report_valid, cell_mv, last_cell, charge_ma, soc_percent, now_ms,
    output ready
  );
endinterface

interface bcst_out_if;
  logic valid;
  logic ready;
  logic battery_normal;
  logic solar_excess;
  logic battery_changed;
  logic solar_changed;
  logic cell_overflow;

  modport source (
    output valid, battery_normal, solar_excess, battery_changed, solar_changed,
           cell_overflow,
    input  ready
  );
  modport sink (
    input  valid, battery_normal, solar_excess, battery_changed, solar_changed,
           cell_overflow,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/battery_cell_and_solar_state_tracker_top.sv
// battery_cell_and_solar_state_tracker_top: battery cell and solar state tracker
// uses bcst_pkg, bcst_in_if/bcst_out_if and bcst_cnt_ram
//
// usage
//   in_i carries one request per item: cell items (mode 0) then one pack item
//   (mode 1) per battery report. out_o returns exactly one result per request,
//   in order, with the battery and solar states after that item.
//   an APB-style port writes and reads the seven configuration registers at
//   byte address 4*index; write only while no request is in flight.
// timing
//   a request is read from the counter memory in its accept cycle, then updated
//   and written back as it leaves the update stage; the result is registered in
//   the output register, which drives out_o.valid. one request per cycle is
//   sustained while out_o.ready stays high; a read of the entry written in the
//   same cycle is forwarded, and a bulk counter clear uses per-entry valid bits.
// reset and stall
//   reset clears all counters, battery low, solar deficiency, registers to
//   their defaults. the output register holds a result while out_o.ready is
//   low; one more request may wait in the update stage, then in_i.ready drops.
`default_nettype none

module battery_cell_and_solar_state_tracker_top #(
  parameter int unsigned MaxCells = bcst_pkg::MaxCellsDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  bcst_in_if.sink                      in_i,
  bcst_out_if.source                   out_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [bcst_pkg::PaddrW-1:0]   paddr,
  input  wire [bcst_pkg::PdataW-1:0]   pwdata,
  output logic [bcst_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned IdxW  = (MaxCells > 1) ? $clog2(MaxCells) : 1;
  localparam int unsigned PosW  = $clog2(MaxCells + 1);
  localparam int unsigned Depth = 2 ** IdxW;

  // configuration
  logic [15:0]                 cell_low_q, cell_high_q, charge_thr_q;
  logic                        track_en_q;
  logic [3:0]                  count_thr_q;
  logic [6:0]                  soc_thr_q;
  logic [31:0]                 retry_q;
  logic [bcst_pkg::ChgMaW-1:0] charge_thr_ma_q;
  logic                        cfg_wr;
  bcst_pkg::reg_idx_e          cfg_idx;

  // tracking state
  logic [PosW-1:0] pos_q, pos_d;
  logic            skip_q, skip_d, all_high_q, all_high_d;
  logic            bat_q, bat_d, sol_q, sol_d;
  logic [31:0]     last_att_q, last_att_d;

  // update stage
  logic               s1_vld_q, s1_adv, in_acc, bat_en;
  logic [PosW-1:0]    s1_pos_q;
  logic               s1_mode_q, s1_rv_q, s1_last_q;
  logic [15:0]        s1_mv_q;
  logic [31:0]        s1_ma_q, s1_now_q;
  logic [6:0]         s1_soc_q;

  // results
  logic bchg, schg, ovf, excess;
  logic out_vld_q;
  logic out_bat_q, out_sol_q, out_bchg_q, out_schg_q, out_ovf_q;

  // counter memory access
  bcst_pkg::cnt_pair_t cnt_rd, cnt_wr;
  logic                cnt_upd, cnt_clr;
  logic [3:0]          low_nx, high_nx;
  logic [31:0]         elapsed;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = bcst_pkg::reg_idx_e'(paddr[4:2]);
  assign bat_en = track_en_q && (cell_low_q < cell_high_q);

  assign in_acc      = in_i.valid && in_i.ready;
  assign s1_adv      = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !s1_vld_q || s1_adv;

  always_comb begin
    case (cfg_idx)
      bcst_pkg::REG_CELL_LOW:   prdata = {16'b0, cell_low_q};
      bcst_pkg::REG_CELL_HIGH:  prdata = {16'b0, cell_high_q};
      bcst_pkg::REG_TRACK_EN:   prdata = {31'b0, track_en_q};
      bcst_pkg::REG_COUNT_THR:  prdata = {28'b0, count_thr_q};
      bcst_pkg::REG_CHARGE_THR: prdata = {16'b0, charge_thr_q};
      bcst_pkg::REG_SOC_THR:    prdata = {25'b0, soc_thr_q};
      bcst_pkg::REG_RETRY:      prdata = retry_q;
      default:                  prdata = '0;
    endcase
  end

  // cell position depends on the request stream and on whether battery tracking is enabled
  always_comb begin
    pos_d = pos_q;
    if (in_i.report_valid) begin
      if (in_i.mode) begin
        pos_d = '0;
      end else if (bat_en) begin
        if (in_i.last_cell) begin
          pos_d = '0;
        end else if (pos_q < PosW'(MaxCells)) begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  bcst_cnt_ram #(
    .Depth (Depth),
    .AddrW (IdxW)
  ) u_cnt_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (pos_q[IdxW-1:0]),
    .wr_en_i   (cnt_upd && !cnt_clr && s1_adv),
    .wr_addr_i (s1_pos_q[IdxW-1:0]),
    .wr_data_i (cnt_wr),
    .clr_i     (cnt_clr && s1_adv),
    .rd_data_o (cnt_rd)
  );

  assign low_nx  = ((s1_mv_q < cell_low_q) && (cnt_rd.low_cnt < bcst_pkg::CntSat)) ?
                   cnt_rd.low_cnt + 4'd1 : cnt_rd.low_cnt;
  assign high_nx = ((s1_mv_q >= cell_high_q) && (cnt_rd.high_cnt < bcst_pkg::CntSat)) ?
                   cnt_rd.high_cnt + 4'd1 : cnt_rd.high_cnt;
  assign elapsed = s1_now_q - last_att_q;
  assign excess  = !s1_ma_q[31] &&
                   ((s1_soc_q >= soc_thr_q) ||
                    (s1_ma_q[30:0] >= {5'b0, charge_thr_ma_q}));

  always_comb begin
    bat_d      = bat_q;
    sol_d      = sol_q;
    skip_d     = skip_q;
    all_high_d = all_high_q;
    last_att_d = last_att_q;
    bchg       = 1'b0;
    schg       = 1'b0;
    ovf        = 1'b0;
    cnt_upd    = 1'b0;
    cnt_clr    = 1'b0;
    cnt_wr     = cnt_rd;
    if (s1_vld_q && s1_rv_q) begin
      if (!s1_mode_q) begin
        if (bat_en) begin
          ovf = (s1_pos_q >= PosW'(MaxCells));
          if (!ovf && !skip_q) begin
            cnt_upd = 1'b1;
            if (bat_q) begin
              cnt_wr.low_cnt = low_nx;
              if (low_nx >= count_thr_q) begin
                bat_d   = 1'b0;
                cnt_clr = 1'b1;
                skip_d  = 1'b1;
                bchg    = 1'b1;
              end
            end else begin
              cnt_wr.high_cnt = high_nx;
              if (high_nx < count_thr_q) begin
                all_high_d = 1'b0;
              end
            end
          end
          if (s1_last_q) begin
            if (!bat_d && !skip_d && !bchg && all_high_d) begin
              bat_d   = 1'b1;
              cnt_clr = 1'b1;
              bchg    = 1'b1;
            end
            skip_d     = 1'b0;
            all_high_d = 1'b1;
          end
        end
      end else begin
        skip_d     = 1'b0;
        all_high_d = 1'b1;
        if ((charge_thr_q != 16'd0) && (sol_q || (elapsed >= retry_q))) begin
          if (excess != sol_q) begin
            schg  = 1'b1;
            sol_d = excess;
            if (!excess) begin
              last_att_d = s1_now_q;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pos_q  <= pos_q;
      s1_mode_q <= in_i.mode;
      s1_rv_q   <= in_i.report_valid;
      s1_last_q <= in_i.last_cell;
      s1_mv_q   <= in_i.cell_mv;
      s1_ma_q   <= in_i.charge_ma;
      s1_soc_q  <= in_i.soc_percent;
      s1_now_q  <= in_i.now_ms;
    end
    if (s1_adv) begin
      out_bat_q  <= bat_d;
      out_sol_q  <= sol_d;
      out_bchg_q <= bchg;
      out_schg_q <= schg;
      out_ovf_q  <= ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_low_q      <= '0;
      cell_high_q     <= '0;
      track_en_q      <= 1'b0;
      count_thr_q     <= bcst_pkg::CountThrRst;
      charge_thr_q    <= '0;
      charge_thr_ma_q <= '0;
      soc_thr_q       <= bcst_pkg::SocThrRst;
      retry_q         <= bcst_pkg::RetryDelayRst;
      pos_q           <= '0;
      skip_q          <= 1'b0;
      all_high_q      <= 1'b1;
      bat_q           <= 1'b0;
      sol_q           <= 1'b0;
      last_att_q      <= '0;
      s1_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_q    <= pos_d;
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        skip_q     <= skip_d;
        all_high_q <= all_high_d;
        bat_q      <= bat_d;
        sol_q      <= sol_d;
        last_att_q <= last_att_d;
        out_vld_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q  <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_idx)
          bcst_pkg::REG_CELL_LOW:  cell_low_q  <= pwdata[15:0];
          bcst_pkg::REG_CELL_HIGH: cell_high_q <= pwdata[15:0];
          bcst_pkg::REG_TRACK_EN: begin
            track_en_q <= pwdata[0];
            if (pwdata[0]) begin
              bat_q <= 1'b0;
            end
          end
          bcst_pkg::REG_COUNT_THR: count_thr_q <= pwdata[3:0];
          bcst_pkg::REG_CHARGE_THR: begin
            charge_thr_q    <= pwdata[15:0];
            charge_thr_ma_q <= bcst_pkg::ChgMaW'({10'b0, pwdata[15:0]} *
                                                 bcst_pkg::ChgMaW'(bcst_pkg::MaPerA));
            sol_q           <= 1'b0;
          end
          bcst_pkg::REG_SOC_THR:   soc_thr_q <= pwdata[6:0];
          bcst_pkg::REG_RETRY:     retry_q   <= pwdata;
          default: ;
        endcase
      end
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.battery_normal  = out_bat_q;
  assign out_o.solar_excess    = out_sol_q;
  assign out_o.battery_changed = out_bchg_q;
  assign out_o.solar_changed   = out_schg_q;
  assign out_o.cell_overflow   = out_ovf_q;

endmodule

`default_nettype wire

FILE: sv/bcst_cnt_ram.sv
// bcst_cnt_ram: per-cell low/high counter memory with a registered read
// entry valid bits for bulk clear, write-to-read forwarding; uses bcst_pkg
`default_nettype none

module bcst_cnt_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     rd_en_i,
  input  wire [AddrW-1:0]         rd_addr_i,
  input  wire                     wr_en_i,
  input  wire [AddrW-1:0]         wr_addr_i,
  input  wire bcst_pkg::cnt_pair_t wr_data_i,
  input  wire                     clr_i,
  output bcst_pkg::cnt_pair_t     rd_data_o
);

  bcst_pkg::cnt_pair_t mem [Depth];
  bcst_pkg::cnt_pair_t rdata_q;
  bcst_pkg::cnt_pair_t fwd_data_q;
  logic [Depth-1:0]    vld_q;
  logic [AddrW-1:0]    rd_addr_q;
  logic                fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
      rd_addr_q  <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      rd_data_o = fwd_data_q;
    end else if (vld_q[rd_addr_q]) begin
      rd_data_o = rdata_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

FILE: sim/battery_cell_and_solar_state_tracker_top_tb.sv
// testbench for battery_cell_and_solar_state_tracker_top: directed and random battery reports
// checked against an in-bench tracker model; needs bcst_pkg, bcst_if and the tracker rtl
`default_nettype none

module battery_cell_and_solar_state_tracker_top_tb;

  localparam int unsigned MaxCells   = bcst_pkg::MaxCellsDefault;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    bit               mode;
    bit               rpt_valid;
    bit [15:0]        cell_mv;
    bit               last_cell;
    bit signed [31:0] charge_ma;
    bit [6:0]         soc_percent;
    bit [31:0]        now_ms;
  } report_item_t;

  typedef struct {
    bit battery_normal;
    bit solar_excess;
    bit battery_changed;
    bit solar_changed;
    bit cell_overflow;
  } tracker_status_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bcst_pkg::PaddrW-1:0] paddr;
  logic [bcst_pkg::PdataW-1:0] pwdata;
  logic [bcst_pkg::PdataW-1:0] prdata;
  logic                        pready;

  bcst_in_if  req_if ();
  bcst_out_if res_if ();

  battery_cell_and_solar_state_tracker_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if.sink),
    .out_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copy
  bit [15:0] cfg_low_mv;
  bit [15:0] cfg_high_mv;
  bit        cfg_track_en;
  bit [3:0]  cfg_count_thr;
  bit [15:0] cfg_charge_a;
  bit [6:0]  cfg_soc_pct;
  bit [31:0] cfg_retry_ms;

  // tracker state copy
  bit [bcst_pkg::CntW-1:0] lo_hits [MaxCells];
  bit [bcst_pkg::CntW-1:0] hi_hits [MaxCells];
  int unsigned   cell_idx;
  bit            report_all_high;
  bit            skip_cells;
  bit            batt_ok;
  bit            solar_ok;
  bit [31:0]     solar_hold_ms;

  report_item_t    report_queue [$];
  tracker_status_t expected_status [$];
  report_item_t    cur_req;
  bit              req_busy;
  bit              take_res;
  int              gap_left;
  int              stall_left;
  int              idle_odds;
  int              err_cnt;
  int unsigned     cycle_cnt;
  bit [31:0]       clock_ms;

  always #1 clk_i = ~clk_i;

  function automatic void wipe_counters();
    for (int i = 0; i < MaxCells; i++) begin
      lo_hits[i] = '0;
      hi_hits[i] = '0;
    end
  endfunction

  function automatic void close_report();
    cell_idx        = 0;
    skip_cells      = 1'b0;
    report_all_high = 1'b1;
  endfunction

  function automatic tracker_status_t track_item(report_item_t it);
    tracker_status_t st;
    bit [31:0]       elapsed;
    longint          ma;
    bit              excess;
    st = '{default: 1'b0};
    if (it.rpt_valid && !it.mode) begin
      if (cfg_track_en && cfg_low_mv < cfg_high_mv) begin
        if (cell_idx >= MaxCells) begin
          st.cell_overflow = 1'b1;
        end else if (!skip_cells) begin
          if (batt_ok) begin
            if (it.cell_mv < cfg_low_mv && lo_hits[cell_idx] < bcst_pkg::CntSat)
              lo_hits[cell_idx]++;
            if (lo_hits[cell_idx] >= cfg_count_thr) begin
              batt_ok = 1'b0;
              wipe_counters();
              skip_cells = 1'b1;
              st.battery_changed = 1'b1;
            end
          end else begin
            if (it.cell_mv >= cfg_high_mv && hi_hits[cell_idx] < bcst_pkg::CntSat)
              hi_hits[cell_idx]++;
            if (hi_hits[cell_idx] < cfg_count_thr) report_all_high = 1'b0;
          end
        end
        if (cell_idx < MaxCells) cell_idx++;
        if (it.last_cell) begin
          if (!batt_ok && !skip_cells && !st.battery_changed && report_all_high) begin
            batt_ok = 1'b1;
            wipe_counters();
            st.battery_changed = 1'b1;
          end
          close_report();
        end
      end
    end else if (it.rpt_valid) begin
      close_report();
      elapsed = it.now_ms - solar_hold_ms;
      if (cfg_charge_a != 0 && (solar_ok || elapsed >= cfg_retry_ms)) begin
        ma = longint'(it.charge_ma);
        excess = (ma >= 0) &&
                 (it.soc_percent >= cfg_soc_pct ||
                  ma >= longint'(cfg_charge_a) * bcst_pkg::MaPerA);
        if (excess != solar_ok) begin
          if (!excess) solar_hold_ms = it.now_ms;
          solar_ok         = excess;
          st.solar_changed = 1'b1;
        end
      end
    end
    st.battery_normal = batt_ok;
    st.solar_excess   = solar_ok;
    return st;
  endfunction

  task automatic write_reg(bcst_pkg::reg_idx_e idx, bit [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bcst_pkg::REG_CELL_LOW:  cfg_low_mv  = value[15:0];
      bcst_pkg::REG_CELL_HIGH: cfg_high_mv = value[15:0];
      bcst_pkg::REG_TRACK_EN: begin
        cfg_track_en = value[0];
        if (value[0]) batt_ok = 1'b0;
      end
      bcst_pkg::REG_COUNT_THR: cfg_count_thr = value[3:0];
      bcst_pkg::REG_CHARGE_THR: begin
        cfg_charge_a = value[15:0];
        solar_ok     = 1'b0;
      end
      bcst_pkg::REG_SOC_THR:   cfg_soc_pct  = value[6:0];
      bcst_pkg::REG_RETRY:     cfg_retry_ms = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(bit [15:0] lo, bit [15:0] hi, bit en, bit [3:0] thr,
                               bit [15:0] chg, bit [6:0] soc, bit [31:0] retry);
    write_reg(bcst_pkg::REG_CELL_LOW, lo);
    write_reg(bcst_pkg::REG_CELL_HIGH, hi);
    write_reg(bcst_pkg::REG_TRACK_EN, en);
    write_reg(bcst_pkg::REG_COUNT_THR, thr);
    write_reg(bcst_pkg::REG_CHARGE_THR, chg);
    write_reg(bcst_pkg::REG_SOC_THR, soc);
    write_reg(bcst_pkg::REG_RETRY, retry);
  endtask

  task automatic drain();
    while (report_queue.size() != 0 || req_busy || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic report_item_t noise_item();
    report_item_t it;
    it.mode        = $urandom;
    it.rpt_valid   = 1'b0;
    it.cell_mv     = $urandom;
    it.last_cell   = $urandom;
    it.charge_ma   = $urandom;
    it.soc_percent = $urandom_range(0, 100);
    it.now_ms      = $urandom;
    return it;
  endfunction

  task automatic push_cell(bit ok, bit [15:0] mv, bit last);
    report_item_t it;
    it           = noise_item();
    it.mode      = 1'b0;
    it.rpt_valid = ok;
    it.cell_mv   = mv;
    it.last_cell = last;
    report_queue.push_back(it);
  endtask

  task automatic push_pack(bit ok, bit signed [31:0] ma, bit [6:0] soc, bit [31:0] now);
    report_item_t it;
    it             = noise_item();
    it.mode        = 1'b1;
    it.rpt_valid   = ok;
    it.charge_ma   = ma;
    it.soc_percent = soc;
    it.now_ms      = now;
    report_queue.push_back(it);
  endtask

  // bias 0/1 mostly recovered cells, 2 mostly low cells, 3 anything
  function automatic bit [15:0] pick_mv(int bias);
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return cfg_low_mv;
      3: return cfg_high_mv;
      default: ;
    endcase
    if (bias == 2 && cfg_low_mv != 0) return $urandom_range(0, int'(cfg_low_mv) - 1);
    if (bias < 2) return $urandom_range(int'(cfg_high_mv), 16'hFFFF);
    return $urandom;
  endfunction

  task automatic random_pack();
    bit signed [31:0] ma;
    bit [6:0]         soc;
    int unsigned      span;
    int unsigned      base_ma;
    base_ma = cfg_charge_a * bcst_pkg::MaPerA;
    case ($urandom_range(0, 5))
      0: ma = $urandom | 32'h8000_0000;
      1: ma = base_ma + $urandom_range(0, 2000) - 1000;
      2: ma = $urandom;
      3: ma = $urandom_range(0, 1000);
      4: ma = base_ma + $urandom_range(0, 100000);
      default: begin
        case ($urandom_range(0, 2))
          0: ma = 32'h7FFF_FFFF;
          1: ma = 32'h8000_0000;
          default: ma = '0;
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) soc = $urandom_range(0, 100);
    else soc = $urandom_range(cfg_soc_pct == 0 ? 0 : int'(cfg_soc_pct) - 1,
                              cfg_soc_pct >= 100 ? 100 : int'(cfg_soc_pct) + 1);
    span = (cfg_retry_ms > 200000) ? 200000 : cfg_retry_ms;
    if ($urandom_range(0, 9) == 0) clock_ms += $urandom;
    else clock_ms += $urandom_range(0, 2 * span + 100);
    push_pack(1'b1, ma, soc, clock_ms);
    if ($urandom_range(0, 19) == 0) report_queue.push_back(noise_item());
  endtask

  task automatic random_report(int base, inout int n);
    int cells;
    int bias;
    bit last;
    cells = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MaxCells + 2) : base;
    bias  = $urandom_range(0, 3);
    for (int i = 0; i < cells; i++) begin
      if ($urandom_range(0, 19) == 0) report_queue.push_back(noise_item());
      last = (i == cells - 1);
      if ($urandom_range(0, 29) == 0) last = !last;
      push_cell(1'b1, pick_mv(bias), last);
      n++;
    end
    if ($urandom_range(0, 9) != 0) begin
      random_pack();
      n++;
    end
  endtask

  task automatic run_phase(int base, int target);
    int n;
    n = 0;
    while (n < target) random_report(base, n);
    drain();
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_status.push_back(track_item(cur_req));
        req_busy = 1'b0;
      end
      if (!req_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
          gap_left = $urandom_range(0, 4);
        end else if (report_queue.size() != 0) begin
          cur_req  = report_queue.pop_front();
          req_busy = 1'b1;
          req_if.mode         <= cur_req.mode;
          req_if.report_valid <= cur_req.rpt_valid;
          req_if.cell_mv      <= cur_req.cell_mv;
          req_if.last_cell    <= cur_req.last_cell;
          req_if.charge_ma    <= cur_req.charge_ma;
          req_if.soc_percent  <= cur_req.soc_percent;
          req_if.now_ms       <= cur_req.now_ms;
        end
      end
      req_if.valid <= req_busy;
    end
  end

  function automatic void check_field(string name, bit want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      err_cnt++;
    end
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_status.size() == 0) begin
          $error("result with no request outstanding");
          err_cnt++;
        end else begin
          tracker_status_t want;
          want = expected_status.pop_front();
          check_field("battery_normal", want.battery_normal, res_if.battery_normal);
          check_field("solar_excess", want.solar_excess, res_if.solar_excess);
          check_field("battery_changed", want.battery_changed, res_if.battery_changed);
          check_field("solar_changed", want.solar_changed, res_if.solar_changed);
          check_field("cell_overflow", want.cell_overflow, res_if.cell_overflow);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        take_res = 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        stall_left = $urandom_range(0, 4);
        take_res   = 1'b0;
      end else begin
        take_res = 1'b1;
      end
      res_if.ready <= take_res;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $error("timeout with %0d results outstanding", expected_status.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clk_i   = 1'b0;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_if.valid        = 1'b0;
    req_if.mode         = 1'b0;
    req_if.report_valid = 1'b0;
    req_if.cell_mv      = '0;
    req_if.last_cell    = 1'b0;
    req_if.charge_ma    = '0;
    req_if.soc_percent  = '0;
    req_if.now_ms       = '0;
    res_if.ready        = 1'b0;

    cfg_low_mv    = '0;
    cfg_high_mv   = '0;
    cfg_track_en  = 1'b0;
    cfg_count_thr = bcst_pkg::CountThrRst;
    cfg_charge_a  = '0;
    cfg_soc_pct   = bcst_pkg::SocThrRst;
    cfg_retry_ms  = bcst_pkg::RetryDelayRst;
    wipe_counters();
    close_report();
    batt_ok       = 1'b0;
    solar_ok      = 1'b0;
    solar_hold_ms = '0;

    req_busy   = 1'b0;
    take_res   = 1'b0;
    gap_left   = 0;
    stall_left = 0;
    idle_odds  = 3;
    err_cnt    = 0;
    cycle_cnt  = 0;
    clock_ms   = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: tracking and solar both off
    push_cell(1'b1, 16'hFFFF, 1'b1);
    push_pack(1'b1, 32'sh7FFF_FFFF, 7'd100, 32'd0);
    drain();

    load_settings(16'd3000, 16'd3500, 1'b1, 4'd1, 16'd5, 7'd90, 32'd0);
    // recover, then solar excess on current
    push_cell(1'b1, 16'd3500, 1'b0);
    push_cell(1'b1, 16'hFFFF, 1'b1);
    push_pack(1'b1, 32'sd5000, 7'd0, 32'd0);
    // low cell drops the battery and skips the rest of the report
    push_cell(1'b1, 16'd2999, 1'b0);
    push_cell(1'b1, 16'd0, 1'b1);
    push_pack(1'b1, 32'sh8000_0000, 7'd100, 32'd10);
    // invalid requests, then a valid pack with the largest charge and time stamp
    push_cell(1'b0, 16'd0, 1'b1);
    push_pack(1'b0, 32'sd5000, 7'd0, 32'd20);
    push_pack(1'b1, 32'sh7FFF_FFFF, 7'd0, 32'hFFFF_FFFF);
    // report longer than the cell capacity
    for (int i = 0; i < MaxCells + 1; i++) push_cell(1'b1, 16'd3600 + i, i == MaxCells);
    push_pack(1'b1, 32'sd0, 7'd89, 32'd5);
    drain();

    idle_odds = 4;
    load_settings(16'd3000, 16'd3400, 1'b1, 4'd1, 16'd1, 7'd0, 32'd0);
    run_phase(4, 95);

    idle_odds = 0;
    load_settings(16'd3200, 16'd3300, 1'b1, 4'd15, 16'hFFFF, 7'd100, 32'd50);
    run_phase(2, 95);

    idle_odds = 3;
    load_settings(16'd0, 16'hFFFF, 1'b1, 4'd3, 16'd300, 7'd50, 32'd1000);
    run_phase(3, 95);

    idle_odds = 6;
    load_settings(16'hFFFF, 16'd0, 1'b1, 4'd2, 16'd10, 7'd90, 32'd120000);
    run_phase(4, 95);

    idle_odds = 2;
    load_settings(16'd1000, 16'd2000, 1'b0, 4'd2, 16'd0, 7'd90, 32'd0);
    run_phase(5, 95);

    idle_odds = 4;
    load_settings(16'd1000, 16'd60000, 1'b1, 4'd2, 16'd2000, 7'd50, 32'hFFFF_FFFF);
    run_phase(MaxCells, 95);

    idle_odds = 0;
    load_settings(16'd3000, 16'd3500, 1'b1, 4'd3, 16'd10, 7'd90, 32'd120000);
    run_phase(4, 95);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: battery_cell_and_solar_state_tracker_top.f
sv/bcst_pkg.sv
sv/bcst_if.sv
sv/bcst_cnt_ram.sv
sv/battery_cell_and_solar_state_tracker_top.sv
sim/battery_cell_and_solar_state_tracker_top_tb.sv
